@@ rtl/thrl_pkg.sv @@
// ----------------------------------------------------------------------------
// thrl_pkg
// Shared types and constants for the heart-rate history log: request and
// result payloads, the decoded command passed between the front end and the
// back end, operation, status and sequencer codes.
// ----------------------------------------------------------------------------
package thrl_pkg;

  // Raw kind codes on the request channel
  localparam logic [1:0] KIND_ADD   = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  // Result status codes
  localparam logic [1:0] STAT_DONE      = 2'd0;
  localparam logic [1:0] STAT_LOGGED    = 2'd1;
  localparam logic [1:0] STAT_ZERO_RATE = 2'd2;
  localparam logic [1:0] STAT_THROTTLED = 2'd3;

  // Most entries one read returns, and the width that holds that number
  localparam int unsigned RESULT_LIMIT = 64;
  localparam int unsigned REQ_W        = 7;

  // Width of the stored_count result field
  localparam int unsigned COUNT_W = 7;

  // Reset value of the minimum interval register
  localparam logic [15:0] MIN_INTERVAL_RST = 16'd30;

  // Command queue between front end and back end
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = 1;
  localparam int unsigned QFILL_W     = 2;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_READ,
    OP_CLEAR,
    OP_NONE
  } op_e;

  typedef enum logic {
    S_IDLE,
    S_READ
  } seq_state_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] sample_time;
    logic [7:0]  heart_rate;
    logic [15:0] request_count;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               entry_valid;
    logic [31:0]        entry_time;
    logic [7:0]         entry_rate;
    logic [COUNT_W-1:0] stored_count;
    logic               last;
  } out_item_t;

  // Decoded command held in the queue
  typedef struct packed {
    op_e              op;
    logic [31:0]      sample_time;
    logic [7:0]       heart_rate;
    logic             zero_rate;
    logic [REQ_W-1:0] req;
  } cmd_t;

  // One row of the log memory
  typedef struct packed {
    logic [31:0] sample_time;
    logic [7:0]  heart_rate;
  } log_entry_t;

endpackage

@@ rtl/throttled_history_ring_log.sv @@
// ----------------------------------------------------------------------------
// throttled_history_ring_log
// Circular log of timestamped heart-rate samples with add throttling.
// ----------------------------------------------------------------------------
// Requests enter a two-entry command queue and are executed by a back end
// that owns a LOG_DEPTH-row memory (one write and one registered read port).
// Add, clear and unused kinds give one result, which passes through the
// queue and then the result register. A read of n entries (n = min(request,
// stored, 64)) first locates the oldest entry and then streams n results,
// one per cycle from the memory read port while out_stall_i is low;
// n = 0 gives a single result. The front end keeps taking requests into the
// queue while the back end streams or waits on out_stall_i, until the queue
// is full. The log memory is not cleared after reset; the entry count keeps
// unwritten rows from ever being returned.
// ----------------------------------------------------------------------------
module throttled_history_ring_log
  import thrl_pkg::*;
#(
  parameter int unsigned LOG_DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_data_o
);

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;

  // Decode and queue requests
  thrl_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  // Execute commands against the log
  thrl_back #(
    .LOG_DEPTH (LOG_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

@@ rtl/thrl_front.sv @@
// ----------------------------------------------------------------------------
// thrl_front
// Request front end: accepts requests, decodes the kind, flags a zero rate,
// clamps the read length to the result limit and queues the decoded command
// for the back end in a two-entry queue.
// ----------------------------------------------------------------------------
module thrl_front
  import thrl_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_item_t in_data_i,
  output logic     cmd_valid_o,
  output cmd_t     cmd_o,
  input  logic     cmd_pop_i
);

  cmd_t               dec_cmd;
  cmd_t               queue_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QFILL_W-1:0] fill_q, fill_d;
  logic               push;
  logic               pop;

  // Decode the request into a command
  always_comb begin
    dec_cmd.sample_time = in_data_i.sample_time;
    dec_cmd.heart_rate  = in_data_i.heart_rate;
    dec_cmd.zero_rate   = (in_data_i.heart_rate == 8'd0);
    if (in_data_i.request_count > 16'(RESULT_LIMIT)) begin
      dec_cmd.req = REQ_W'(RESULT_LIMIT);
    end else begin
      dec_cmd.req = in_data_i.request_count[REQ_W-1:0];
    end
    case (in_data_i.kind)
      KIND_ADD:   dec_cmd.op = OP_ADD;
      KIND_READ:  dec_cmd.op = OP_READ;
      KIND_CLEAR: dec_cmd.op = OP_CLEAR;
      default:    dec_cmd.op = OP_NONE;
    endcase
  end

  assign in_stall_o  = (fill_q == QFILL_W'(QUEUE_DEPTH));
  assign push        = in_valid_i && !in_stall_o;
  assign pop         = cmd_pop_i && cmd_valid_o;
  assign cmd_valid_o = (fill_q != '0);
  assign cmd_o       = queue_q[rd_ptr_q];

  // Advance the queue pointers and fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      fill_d = fill_q + 1'b1;
    end else if (pop && !push) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // Hold queued commands
  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= dec_cmd;
    end
  end

endmodule

@@ rtl/thrl_back.sv @@
// ----------------------------------------------------------------------------
// thrl_back
// Command back end: owns the log memory, write pointer, entry count, last
// logged time and the interval register. Adds are refused for a zero rate,
// throttled or written; reads stream entries oldest first through the
// registered memory read, which doubles as the result register.
// ----------------------------------------------------------------------------
module thrl_back
  import thrl_pkg::*;
#(
  parameter int unsigned LOG_DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        cmd_valid_i,
  input  cmd_t        cmd_i,
  output logic        cmd_pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_data_o
);

  localparam int unsigned AW = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
  localparam int unsigned CW = $clog2(LOG_DEPTH + 1);
  localparam int unsigned MW = (CW > REQ_W) ? CW : REQ_W;
  localparam int unsigned SW = ((AW > REQ_W) ? AW : REQ_W) + 1;

  log_entry_t         log_mem [LOG_DEPTH];
  log_entry_t         rdata_q;

  seq_state_e         state_q, state_d;
  logic [AW-1:0]      wp_q, wp_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic [31:0]        last_q, last_d;
  logic [15:0]        min_q;
  logic [AW-1:0]      rd_ptr_q, rd_ptr_d;
  logic [REQ_W-1:0]   rd_left_q, rd_left_d;

  logic               out_valid_q, out_valid_d;
  logic [1:0]         out_status_q, meta_status;
  logic               out_ev_q, meta_ev;
  logic [COUNT_W-1:0] out_cnt_q, meta_cnt;
  logic               out_last_q, meta_last;

  logic               adv;
  logic               load_meta;
  logic               load_entry;
  logic               mem_we;
  logic [31:0]        since_last;
  logic               throttled;
  logic [MW-1:0]      req_ext, cnt_ext, n_ext;
  logic [REQ_W-1:0]   n_rd;
  logic [SW-1:0]      wp_s, n_s, start_s;

  assign adv = !out_valid_q || !out_stall_i;

  // Throttle test with wrapping subtraction
  assign since_last = cmd_i.sample_time - last_q;
  assign throttled  = (last_q != 32'd0) && (since_last < {16'd0, min_q});

  // Entries to return and the oldest slot among them
  assign req_ext = MW'(cmd_i.req);
  assign cnt_ext = MW'(cnt_q);
  assign n_ext   = (req_ext < cnt_ext) ? req_ext : cnt_ext;
  assign n_rd    = n_ext[REQ_W-1:0];
  assign wp_s    = SW'(wp_q);
  assign n_s     = SW'(n_rd);
  assign start_s = (wp_s >= n_s) ? (wp_s - n_s) : (wp_s + SW'(LOG_DEPTH) - n_s);

  // Sequence commands and select the next result
  always_comb begin
    state_d     = state_q;
    wp_d        = wp_q;
    cnt_d       = cnt_q;
    last_d      = last_q;
    rd_ptr_d    = rd_ptr_q;
    rd_left_d   = rd_left_q;
    cmd_pop_o   = 1'b0;
    load_meta   = 1'b0;
    load_entry  = 1'b0;
    mem_we      = 1'b0;
    meta_status = STAT_DONE;
    meta_ev     = 1'b0;
    meta_last   = 1'b1;
    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i && adv) begin
          cmd_pop_o = 1'b1;
          case (cmd_i.op)
            OP_ADD: begin
              load_meta = 1'b1;
              if (cmd_i.zero_rate) begin
                meta_status = STAT_ZERO_RATE;
              end else if (throttled) begin
                meta_status = STAT_THROTTLED;
              end else begin
                meta_status = STAT_LOGGED;
                mem_we      = 1'b1;
                last_d      = cmd_i.sample_time;
                wp_d        = (wp_q == AW'(LOG_DEPTH - 1)) ? '0 : wp_q + 1'b1;
                if (cnt_q != CW'(LOG_DEPTH)) begin
                  cnt_d = cnt_q + 1'b1;
                end
              end
            end
            OP_READ: begin
              if (n_rd == '0) begin
                load_meta = 1'b1;
              end else begin
                state_d   = S_READ;
                rd_ptr_d  = start_s[AW-1:0];
                rd_left_d = n_rd;
              end
            end
            OP_CLEAR: begin
              load_meta = 1'b1;
              wp_d      = '0;
              cnt_d     = '0;
              last_d    = 32'd0;
            end
            default: begin
              load_meta = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        if (adv) begin
          load_meta  = 1'b1;
          load_entry = 1'b1;
          meta_ev    = 1'b1;
          meta_last  = (rd_left_q == REQ_W'(1));
          rd_ptr_d   = (rd_ptr_q == AW'(LOG_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
          rd_left_d  = rd_left_q - 1'b1;
          if (meta_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    meta_cnt = COUNT_W'(cnt_d);
  end

  // Load the result register, drop it once taken
  always_comb begin
    if (load_meta) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wp_q        <= '0;
      cnt_q       <= '0;
      last_q      <= 32'd0;
      min_q       <= MIN_INTERVAL_RST;
      rd_ptr_q    <= '0;
      rd_left_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wp_q        <= wp_d;
      cnt_q       <= cnt_d;
      last_q      <= last_d;
      rd_ptr_q    <= rd_ptr_d;
      rd_left_q   <= rd_left_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        min_q <= cfg_wdata_i;
      end
    end
  end

  // Hold result fields
  always_ff @(posedge clk_i) begin
    if (load_meta) begin
      out_status_q <= meta_status;
      out_ev_q     <= meta_ev;
      out_cnt_q    <= meta_cnt;
      out_last_q   <= meta_last;
    end
  end

  // Write logged samples
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      log_mem[wp_q] <= '{sample_time: cmd_i.sample_time, heart_rate: cmd_i.heart_rate};
    end
  end

  // Read the next entry into the result register
  always_ff @(posedge clk_i) begin
    if (load_entry) begin
      rdata_q <= log_mem[rd_ptr_q];
    end
  end

  assign out_valid_o             = out_valid_q;
  assign out_data_o.status       = out_status_q;
  assign out_data_o.entry_valid  = out_ev_q;
  assign out_data_o.entry_time   = out_ev_q ? rdata_q.sample_time : 32'd0;
  assign out_data_o.entry_rate   = out_ev_q ? rdata_q.heart_rate : 8'd0;
  assign out_data_o.stored_count = out_cnt_q;
  assign out_data_o.last         = out_last_q;

endmodule

@@ rtl/thrl_checker.sv @@
// ----------------------------------------------------------------------------
// thrl_checker
// Port-level checks for the history log: result stability under stall and
// consistency of the result fields.
// ----------------------------------------------------------------------------
module thrl_checker
  import thrl_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cfg_we_i,
  input logic [15:0] cfg_wdata_i,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input in_item_t    in_data_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input out_item_t   out_data_o
);

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed or dropped");

  // Zero entry fields on results without an entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.entry_valid |->
      out_data_o.entry_time == 32'd0 && out_data_o.entry_rate == 8'd0)
    else $error("entry fields not zero without an entry");

  // Entries come only from reads
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.entry_valid |-> out_data_o.status == STAT_DONE)
    else $error("entry carried by a non-read result");

  // Add results are single and carry no entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != STAT_DONE |->
      out_data_o.last && !out_data_o.entry_valid)
    else $error("add result not single");

endmodule

bind throttled_history_ring_log thrl_checker u_thrl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cfg_we_i    (cfg_we_i),
  .cfg_wdata_i (cfg_wdata_i),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
